@@ sv/lph_pkg.sv @@
// Shared types, constants and codes for the linear probing hash map.
package lph_pkg;

   // Number of slots; must be a power of two so that the home slot is the low key bits.
   localparam int TableSize = 256;
   localparam int SlotW     = $clog2(TableSize);

   localparam logic [1:0] OpInsert = 2'd0;
   localparam logic [1:0] OpFind   = 2'd1;
   localparam logic [1:0] OpDelete = 2'd2;

   localparam logic [1:0] StatOk   = 2'd0;
   localparam logic [1:0] StatMiss = 2'd1;
   localparam logic [1:0] StatFull = 2'd2;

   typedef struct packed {
      logic [1:0]         func;
      logic [63:0]        key;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] found_value;
      logic [1:0]         status;
   } rsp_type;

endpackage

@@ sv/linear_probe_hash_map.sv @@
// Top level of the linear probing hash map: sequencer, key and value memories.
//
// Request words (req_data: func, key, value) come in on req_valid/req_stall and each
// produces exactly one response word (found_value, status) on rsp_valid/rsp_stall.
// One request is worked on at a time; req_stall is high from acceptance until its
// result has been moved into the output register.
// Insert, find and delete probe from the home slot (low key bits) onward, one
// key-memory read per cycle, and wrap from the last slot to slot 0. An item probes
// between 1 and 256 slots. Find or delete with key 0 and the unused code skip the probe.
// A new request is accepted while the previous response still waits in the output
// register; if the receiver stalls, a finished result waits in its own register and
// the block takes no further request until the output register is free.
// Reset marks every slot empty at once through per-slot valid bits, so no clearing
// pass is needed and the block accepts a request in the first cycle after reset.
module linear_probe_hash_map (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  lph_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output lph_pkg::rsp_type rsp_data
);

   localparam logic [1:0] StIdle   = 2'd0;
   localparam logic [1:0] StProbe  = 2'd1;
   localparam logic [1:0] StResult = 2'd2;

   localparam int SlotW = lph_pkg::SlotW;
   localparam int CntW  = SlotW + 1;

   logic [63:0]        key_mem [lph_pkg::TableSize];
   logic signed [31:0] val_mem [lph_pkg::TableSize];

   logic [1:0]               state_ff, state_in;
   logic [1:0]               op_ff;
   logic [63:0]              key_ff;
   logic signed [31:0]       val_ff;
   logic [SlotW-1:0]         slot_ff, slot_in;
   logic [CntW-1:0]          cnt_ff, cnt_in;
   logic                     rd_vld_ff, rd_vld_in;
   logic                     rd_last_ff, rd_last_in;
   logic [SlotW-1:0]         rd_slot_ff;
   logic [63:0]              key_rd_ff;
   logic signed [31:0]       val_rd_ff;
   logic                     kv_rd_ff;
   logic [lph_pkg::TableSize-1:0] valid_ff;
   lph_pkg::rsp_type         res_ff, res_in;
   lph_pkg::rsp_type         rsp_ff;
   logic                     rsp_valid_ff, rsp_valid_in;

   logic        req_accept;
   logic        issue;
   logic        hit;
   logic        miss_end;
   logic        load_out;
   logic [63:0] want_key;
   logic [63:0] eff_key;

   assign req_stall  = (state_ff != StIdle);
   assign req_accept = req_valid && (state_ff == StIdle);
   assign load_out   = (state_ff == StResult) && (!rsp_valid_ff || !rsp_stall);

   // Insert looks for an empty slot, find and delete for the key itself.
   assign want_key = (op_ff == lph_pkg::OpInsert) ? 64'd0 : key_ff;
   assign eff_key  = kv_rd_ff ? key_rd_ff : 64'd0;
   assign hit      = rd_vld_ff && (eff_key == want_key);
   assign miss_end = rd_vld_ff && !hit && rd_last_ff;
   assign issue    = (state_ff == StProbe) && !hit && !miss_end &&
                     (cnt_ff != CntW'(lph_pkg::TableSize));

   always_comb begin
      state_in     = state_ff;
      slot_in      = slot_ff;
      cnt_in       = cnt_ff;
      rd_vld_in    = 1'b0;
      rd_last_in   = 1'b0;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end

      unique case (state_ff)
         StIdle: begin
            if (req_accept) begin
               res_in.found_value = 32'sd0;
               res_in.status      = lph_pkg::StatOk;
               slot_in            = req_data.key[SlotW-1:0];
               cnt_in             = '0;
               if (req_data.func == lph_pkg::OpInsert) begin
                  state_in = StProbe;
               end else if (req_data.func == lph_pkg::OpFind ||
                            req_data.func == lph_pkg::OpDelete) begin
                  if (req_data.key == 64'd0) begin
                     res_in.status = lph_pkg::StatMiss;
                     state_in      = StResult;
                  end else begin
                     state_in = StProbe;
                  end
               end else begin
                  state_in = StResult;
               end
            end
         end
         StProbe: begin
            if (issue) begin
               slot_in    = (slot_ff == SlotW'(lph_pkg::TableSize - 1)) ? '0 : slot_ff + 1'b1;
               cnt_in     = cnt_ff + 1'b1;
               rd_vld_in  = 1'b1;
               rd_last_in = (cnt_ff == CntW'(lph_pkg::TableSize - 1));
            end
            if (hit) begin
               if (op_ff == lph_pkg::OpFind) begin
                  res_in.found_value = val_rd_ff;
               end
               res_in.status = lph_pkg::StatOk;
               state_in      = StResult;
            end else if (miss_end) begin
               res_in.status = (op_ff == lph_pkg::OpInsert) ? lph_pkg::StatFull
                                                            : lph_pkg::StatMiss;
               state_in      = StResult;
            end
         end
         StResult: begin
            if (load_out) begin
               state_in = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         // A deleted slot simply loses its valid bit and reads as empty from then on.
         if (hit && op_ff == lph_pkg::OpInsert) begin
            valid_ff[rd_slot_ff] <= 1'b1;
         end else if (hit && op_ff == lph_pkg::OpDelete) begin
            valid_ff[rd_slot_ff] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      slot_ff    <= slot_in;
      cnt_ff     <= cnt_in;
      rd_last_ff <= rd_last_in;
      res_ff     <= res_in;
      if (req_accept) begin
         op_ff  <= req_data.func;
         key_ff <= req_data.key;
         val_ff <= req_data.value;
      end
      if (issue) begin
         rd_slot_ff <= slot_ff;
         kv_rd_ff   <= valid_ff[slot_ff];
      end
      if (load_out) begin
         rsp_ff <= res_ff;
      end
   end

   // Key and value memories share the probe address; the write lands after the probe ends.
   always_ff @(posedge clock) begin
      if (hit && op_ff == lph_pkg::OpInsert) begin
         key_mem[rd_slot_ff] <= key_ff;
         val_mem[rd_slot_ff] <= val_ff;
      end
      if (issue) begin
         key_rd_ff <= key_mem[slot_ff];
         val_rd_ff <= val_mem[slot_ff];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the linear probing hash map: directed and random requests.
`timescale 1ns / 100ps

module testbench;

   // The package names only the three live operations.
   localparam logic [1:0] OpUnused    = 2'd3;
   localparam int         CycleLimit  = 3_000_000;
   localparam int         DrainCycles = lph_pkg::TableSize + 40;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   lph_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   lph_pkg::rsp_type rsp_data;

   // Shadow copy of the map contents, updated as each request word is accepted.
   logic [63:0]        slot_keys   [lph_pkg::TableSize];
   logic signed [31:0] slot_values [lph_pkg::TableSize];
   lph_pkg::rsp_type   lookup_results_due [$];
   logic [63:0]        key_pool [$];

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int mismatches    = 0;
   int cycles        = 0;
   int n_ops    [4];
   int n_status [4];

   linear_probe_hash_map u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("Timed out after %0d cycles with %0d responses outstanding", cycles,
                  lookup_results_due.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_stall <= !reset && (int'($urandom_range(99)) < stall_pct);
   end

   task automatic log_mismatch(input string what);
      $display("MISMATCH at cycle %0d: %s", cycles, what);
      mismatches++;
   endtask

   always @(posedge clock) begin
      lph_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (lookup_results_due.size() == 0) begin
            log_mismatch($sformatf("response word with nothing outstanding: %p", rsp_data));
         end else begin
            want = lookup_results_due.pop_front();
            if (rsp_data.found_value !== want.found_value)
               log_mismatch($sformatf("found_value %0d, predicted %0d",
                                      rsp_data.found_value, want.found_value));
            if (rsp_data.status !== want.status)
               log_mismatch($sformatf("status %0d, predicted %0d",
                                      rsp_data.status, want.status));
         end
      end
   end

   // Walks each slot at most once from the home slot, stopping at the first match and wrapping at the end of the table.
   function automatic bit probe_for_key(input logic [63:0] home_key, input logic [63:0] want,
                                        output int where);
      int slot;
      slot  = int'(home_key % lph_pkg::TableSize);
      where = 0;
      for (int n = 0; n < lph_pkg::TableSize; n++) begin
         if (slot_keys[slot] == want) begin
            where = slot;
            return 1'b1;
         end
         slot = (slot + 1) % lph_pkg::TableSize;
      end
      return 1'b0;
   endfunction

   function automatic lph_pkg::rsp_type apply_map_op(input lph_pkg::req_type w);
      lph_pkg::rsp_type r;
      int               slot;
      r.found_value = '0;
      r.status      = lph_pkg::StatOk;
      case (w.func)
         lph_pkg::OpInsert: begin
            if (probe_for_key(w.key, 64'd0, slot)) begin
               slot_keys[slot]   = w.key;
               slot_values[slot] = w.value;
            end else begin
               r.status = lph_pkg::StatFull;
            end
         end
         lph_pkg::OpFind: begin
            if (w.key != 64'd0 && probe_for_key(w.key, w.key, slot))
               r.found_value = slot_values[slot];
            else
               r.status = lph_pkg::StatMiss;
         end
         lph_pkg::OpDelete: begin
            if (w.key != 64'd0 && probe_for_key(w.key, w.key, slot))
               slot_keys[slot] = '0;
            else
               r.status = lph_pkg::StatMiss;
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic int used_slots();
      int used;
      used = 0;
      foreach (slot_keys[i])
         if (slot_keys[i] != 64'd0) used++;
      return used;
   endfunction

   // Most keys are reused or crowd round the wrap point so that probe chains grow long.
   function automatic logic [63:0] pick_key();
      int unsigned pick;
      logic [63:0] k;
      pick = $urandom_range(99);
      k    = {$urandom, $urandom};
      if (pick < 55 && key_pool.size() != 0)
         k = key_pool[$urandom_range(key_pool.size() - 1)];
      else if (pick < 75)
         k[lph_pkg::SlotW-1:0] = lph_pkg::SlotW'(lph_pkg::TableSize - 4 + $urandom_range(7));
      else if (pick >= 98)
         k = '1;
      else if (pick >= 96)
         k = '0;
      return k;
   endfunction

   task automatic send_word(input logic [1:0] func, input logic [63:0] key,
                            input logic signed [31:0] value);
      lph_pkg::req_type w;
      lph_pkg::rsp_type r;
      w.func  = func;
      w.key   = key;
      w.value = value;
      while (int'($urandom_range(99)) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (req_stall);
      r = apply_map_op(w);
      lookup_results_due.push_back(r);
      n_ops[func]++;
      n_status[r.status]++;
      if (func == lph_pkg::OpInsert && key != 64'd0 && r.status == lph_pkg::StatOk) begin
         key_pool.push_back(key);
         if (key_pool.size() > 48) void'(key_pool.pop_front());
      end
   endtask

   // Always lets at least one edge pass, so valid is never lowered and raised in one step.
   task automatic wait_results_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (lookup_results_due.size() != 0);
   endtask

   task automatic test_basic_ops();
      send_word(lph_pkg::OpFind,   64'd5, 32'sd0);
      send_word(lph_pkg::OpDelete, 64'd5, 32'sd0);
      send_word(lph_pkg::OpInsert, '1, 32'sh7FFF_FFFF);
      // The first collides with the key above and wraps to slot 0; the second, homed at slot 0, lands in slot 1.
      send_word(lph_pkg::OpInsert, 64'h0000_0001_0000_00FF, 32'sh8000_0000);
      send_word(lph_pkg::OpInsert, 64'h8000_0000_0000_0000, 32'sd7);
      send_word(lph_pkg::OpFind,   '1, 32'sd0);
      send_word(lph_pkg::OpFind,   64'h0000_0001_0000_00FF, 32'sd0);
      send_word(lph_pkg::OpFind,   64'h8000_0000_0000_0000, 32'sd0);
      send_word(lph_pkg::OpInsert, 64'd1, -32'sd1);
      send_word(lph_pkg::OpInsert, 64'd1, 32'sd5);
      send_word(lph_pkg::OpFind,   64'd1, 32'sd0);
      send_word(lph_pkg::OpDelete, 64'd1, 32'sd0);
      // The emptied slot must not end the search for the duplicate further on.
      send_word(lph_pkg::OpFind,   64'd1, 32'sd0);
      send_word(lph_pkg::OpFind,   64'd0, 32'sd0);
      send_word(lph_pkg::OpDelete, 64'd0, 32'sd0);
      send_word(lph_pkg::OpInsert, 64'd0, 32'sd123);
      send_word(lph_pkg::OpFind,   64'd0, 32'sd0);
      send_word(OpUnused,          64'h8000_0000_0000_0000, 32'sd9);
      send_word(lph_pkg::OpDelete, '1, 32'sd0);
      send_word(lph_pkg::OpFind,   '1, 32'sd0);
      send_word(lph_pkg::OpFind,   64'h0000_0001_0000_00FF, 32'sd0);
      send_word(lph_pkg::OpFind,   64'd256, 32'sd0);
      send_word(lph_pkg::OpInsert, 64'd256, 32'sh5A5A_A5A5);
      send_word(lph_pkg::OpFind,   64'd256, 32'sd0);
   endtask

   task automatic test_random_ops(input int count, input int ins_w, input int find_w,
                                  input int del_w);
      int unsigned pick;
      logic [1:0]  func;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         if (pick < ins_w)                       func = lph_pkg::OpInsert;
         else if (pick < ins_w + find_w)         func = lph_pkg::OpFind;
         else if (pick < ins_w + find_w + del_w) func = lph_pkg::OpDelete;
         else                                    func = OpUnused;
         send_word(func, pick_key(), $urandom);
         if (i == count / 2) wait_results_drained();
      end
   endtask

   task automatic test_table_full();
      logic [63:0] k;
      while (used_slots() < lph_pkg::TableSize) begin
         k = {$urandom, $urandom};
         if ($urandom_range(1)) k[lph_pkg::SlotW-1:0] = lph_pkg::SlotW'($urandom_range(15));
         if (k == 64'd0) k = 64'd1;
         send_word(lph_pkg::OpInsert, k, $urandom);
      end
      wait_results_drained();
      repeat (3) send_word(lph_pkg::OpInsert, {$urandom, $urandom} | 64'd1, $urandom);
      send_word(lph_pkg::OpInsert, 64'd0, $urandom);
      repeat (12) send_word(lph_pkg::OpFind, pick_key(), $urandom);
      repeat (6) begin
         send_word(lph_pkg::OpDelete, key_pool[$urandom_range(key_pool.size() - 1)],
                   $urandom);
         send_word(lph_pkg::OpInsert, {$urandom, $urandom} | 64'd1, $urandom);
         send_word(lph_pkg::OpInsert, {$urandom, $urandom} | 64'd1, $urandom);
      end
      repeat (40) send_word(lph_pkg::OpDelete, pick_key(), $urandom);
   endtask

   initial begin
      foreach (slot_keys[i]) begin
         slot_keys[i]   = '0;
         slot_values[i] = '0;
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_basic_ops();
      test_random_ops(60, 40, 30, 25);

      send_idle_pct = 78;
      test_random_ops(60, 40, 30, 25);

      send_idle_pct = 0;
      stall_pct     = 78;
      test_table_full();
      test_random_ops(50, 25, 35, 35);

      send_idle_pct = 31;
      stall_pct     = 31;
      test_random_ops(50, 30, 30, 35);

      wait_results_drained();
      repeat (DrainCycles) @(posedge clock);

      $display("Requests sent: %0d inserts, %0d finds, %0d deletes, %0d with the unused code",
               n_ops[lph_pkg::OpInsert], n_ops[lph_pkg::OpFind], n_ops[lph_pkg::OpDelete],
               n_ops[OpUnused]);
      $display("Outcomes: %0d done or hit, %0d not found, %0d rejected on a full table",
               n_status[lph_pkg::StatOk], n_status[lph_pkg::StatMiss],
               n_status[lph_pkg::StatFull]);
      if (mismatches == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

@@ linear_probe_hash_map.f @@
sv/lph_pkg.sv
sv/linear_probe_hash_map.sv
tb/testbench.sv
